FILE: sv/sha512_hash_core_macros.svh
// Assertion macros for the checks in the core's top-level file.
`ifndef SHA512_HASH_CORE_MACROS_SVH
`define SHA512_HASH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sha512_pkg.sv
`timescale 1ns / 1ps

package sha512_pkg;

    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [6:0]  FULL_WORD_BITS = 7'd64;

    // One classified message word handed from the front to the back.
    typedef struct packed {
        logic [63:0] word;      // word with padding already merged in
        logic [6:0]  add_bits;  // message bits this word carries
        logic        last;      // final word of the message
        logic        extra_pad; // a separate padding word must follow
    } q_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
        rotr64 = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_sigma0(input logic [63:0] x);
        big_sigma0 = rotr64(x, 28) ^ rotr64(x, 34) ^ rotr64(x, 39);
    endfunction

    function automatic logic [63:0] big_sigma1(input logic [63:0] x);
        big_sigma1 = rotr64(x, 14) ^ rotr64(x, 18) ^ rotr64(x, 41);
    endfunction

    function automatic logic [63:0] small_sigma0(input logic [63:0] x);
        small_sigma0 = rotr64(x, 1) ^ rotr64(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] small_sigma1(input logic [63:0] x);
        small_sigma1 = rotr64(x, 19) ^ rotr64(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] v;
        unique case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            3'd7: v = 64'h5be0cd19137e2179;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_const(input logic [6:0] t);
        logic [63:0] k;
        unique case (t)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/sha512_hash_core.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid/in_ready    message_word[63:0], byte_count[3:0], last_word
// out      out_valid/out_ready  digest_word[63:0], word_number[2:0], last_of_digest
//
// A message word enters through a two-entry queue, so the input side can take up to
// two items while the compression engine is busy. Words load into the schedule while
// the queue has items; every sixteenth word starts the rounds on the single round
// unit, which reads no words meanwhile, and a final step folds the result into the
// hash. After the last word, padding fills up to 17 more slots and takes one or two
// more compressions before the eight digest words are offered, one per cycle while
// out_ready is high. Reset is asynchronous and restores the initial hash values; the
// output side may stall for any time, and the input queue simply fills and holds.

module sha512_hash_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_of_digest
);
    import sha512_pkg::*;

    `include "sha512_hash_core_macros.svh"

    // Classified words travel from the front queue to the engine as one struct.
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_data;
    // The final digest word is being taken this cycle.
    logic     out_done;

    sha512_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop)
    );

    // The engine absorbs words, pads, compresses and sends out the digest.
    sha512_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_number    (word_number),
        .last_of_digest (last_of_digest)
    );

    assign out_done = out_valid && out_ready && last_of_digest;

    // A full queue must have an item waiting for the engine.
    `SHA_ASSERT_NOW(a_full_has_item, clk, rst_n, !in_ready, q_valid, "full queue without item")
    // The engine never takes from an empty queue.
    `SHA_ASSERT_NOW(a_pop_valid, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    // After the final digest word is taken the output goes quiet.
    `SHA_ASSERT_NEXT(a_digest_end, clk, rst_n, out_done, !out_valid, "digest did not end")

endmodule

FILE: sv/sha512_front.sv
`timescale 1ns / 1ps

module sha512_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [63:0]          message_word,
    input  logic [3:0]           byte_count,
    input  logic                 last_word,
    output logic                 q_valid,
    output sha512_pkg::q_entry_t q_data,
    input  logic                 q_pop
);
    import sha512_pkg::*;

    q_entry_t    fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [3:0]  cnt_sat;
    logic [6:0]  shamt;
    logic        push;
    q_entry_t    cls;

    // Merge the trailing one-bit into a short last word and mark full last words.
    always_comb begin
        cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
        shamt   = {cnt_sat, 3'b000};
        cls.last = last_word;
        if (!last_word) begin
            cls.word      = message_word;
            cls.add_bits  = FULL_WORD_BITS;
            cls.extra_pad = 1'b0;
        end else if (cnt_sat == 4'd8) begin
            cls.word      = message_word;
            cls.add_bits  = FULL_WORD_BITS;
            cls.extra_pad = 1'b1;
        end else begin
            cls.word      = (message_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> shamt))
                          | (PAD_WORD >> shamt);
            cls.add_bits  = shamt;
            cls.extra_pad = 1'b0;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: sv/sha512_back.sv
`timescale 1ns / 1ps

module sha512_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sha512_pkg::q_entry_t q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          digest_word,
    output logic [2:0]           word_number,
    output logic                 last_of_digest
);
    import sha512_pkg::*;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    state_t      cont;
    logic [3:0]  wib_reg;
    logic [6:0]  round_reg;
    logic [63:0] bitlen_reg;
    logic        first_zero_reg;
    logic [2:0]  idx_reg;
    logic [63:0] hash_reg  [8];
    logic [63:0] vars_reg  [8];
    logic [63:0] sched_reg [16];
    logic        absorb;
    logic [63:0] absorb_word;
    logic        out_take;
    logic [63:0] w_new, t1, t2;

    always_comb begin
        q_pop       = 1'b0;
        absorb      = 1'b0;
        absorb_word = '0;
        cont        = ST_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop       = q_valid;
                absorb      = q_valid;
                absorb_word = q_data.word;
                if (!q_data.last)
                    cont = ST_IDLE;
                else if (q_data.extra_pad)
                    cont = ST_PAD;
                else
                    cont = ST_ZERO;
            end
            ST_PAD:
            begin
                absorb      = 1'b1;
                absorb_word = PAD_WORD;
                cont        = ST_ZERO;
            end
            ST_ZERO:
            begin
                absorb = 1'b1;
                // The length goes in the last slot, unless padding started there.
                if (wib_reg == 4'd15 && !first_zero_reg)
                begin
                    absorb_word = bitlen_reg;
                    cont        = ST_OUT;
                end
                else
                begin
                    absorb_word = '0;
                    cont        = ST_ZERO;
                end
            end
            default:
            begin
                cont = ST_IDLE;
            end
        endcase
    end

    assign out_take = out_valid && out_ready;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE, ST_PAD, ST_ZERO:
            begin
                if (absorb && wib_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                    ret_next   = cont;
                end
                else if (absorb)
                begin
                    state_next = cont;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (out_take && idx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_new = small_sigma1(sched_reg[14]) + sched_reg[9]
              + small_sigma0(sched_reg[1]) + sched_reg[0];
        t1 = vars_reg[7] + big_sigma1(vars_reg[4])
           + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
           + round_const(round_reg) + sched_reg[0];
        t2 = big_sigma0(vars_reg[0])
           + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[1] & vars_reg[2])
              ^ (vars_reg[2] & vars_reg[0]));
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign digest_word    = hash_reg[idx_reg];
    assign word_number    = idx_reg;
    assign last_of_digest = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            wib_reg        <= 4'd0;
            round_reg      <= 7'd0;
            bitlen_reg     <= '0;
            first_zero_reg <= 1'b0;
            idx_reg        <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
                vars_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (q_pop)
                bitlen_reg <= bitlen_reg + {57'd0, q_data.add_bits};
            if (absorb)
            begin
                wib_reg        <= wib_reg + 4'd1;
                first_zero_reg <= (state_reg != ST_ZERO);
                if (wib_reg == 4'd15)
                begin
                    for (int i = 0; i < 8; i++)
                        vars_reg[i] <= hash_reg[i];
                end
            end
            if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 7'd1;
                for (int i = 1; i < 8; i++)
                    if (i != 4)
                        vars_reg[i] <= vars_reg[i - 1];
                vars_reg[4] <= vars_reg[3] + t1;
                vars_reg[0] <= t1 + t2;
            end
            if (state_reg == ST_FINAL)
            begin
                round_reg <= 7'd0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + vars_reg[i];
            end
            if (out_take)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    bitlen_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= init_hash(3'(i));
                end
            end
        end
    end

    // Rolling schedule: words shift in while a block fills, and each round
    // shifts out the word it used and appends the one sixteen rounds ahead.
    always_ff @(posedge clk)
    begin
        if (absorb || state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= absorb ? absorb_word : w_new;
        end
    end

endmodule

FILE: tb/sv/sha512_digest_checker.sv
`timescale 1ns / 1ps

module sha512_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  byte_count,
    input  logic        last_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] digest_word,
    input  logic [2:0]  word_number,
    input  logic        last_of_digest,
    output int          error_count,
    output int          pending_count
);
    import sha512_pkg::*;

    typedef struct {
        logic [63:0] digest;
        logic [2:0]  index;
        logic        tail;
    } digest_entry_t;

    digest_entry_t digest_queue[$];
    logic [63:0]   hash_acc[8];
    logic [63:0]   block_buf[16];
    int unsigned   fill_slot;
    logic [63:0]   msg_bits;

    function automatic logic [63:0] ror(input logic [63:0] x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] round_constant(input int t);
        logic [63:0] k[80] = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
            64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
            64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
            64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
            64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
            64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
            64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
            64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
            64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
            64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
            64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
            64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
            64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
            64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
            64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
            64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
            64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
            64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
            64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
            64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
            64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return k[t];
    endfunction

    task automatic compress_block();
        logic [63:0] v[8];
        logic [63:0] w[16];
        logic [63:0] t1;
        logic [63:0] t2;
        for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                w[t % 16] = w[t % 16] + w[(t - 7) % 16]
                    + (ror(w[(t - 2) % 16], 19) ^ ror(w[(t - 2) % 16], 61)
                       ^ (w[(t - 2) % 16] >> 6))
                    + (ror(w[(t - 15) % 16], 1) ^ ror(w[(t - 15) % 16], 8)
                       ^ (w[(t - 15) % 16] >> 7));
            end
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_constant(t) + w[t % 16];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                + ((v[0] & v[1]) ^ (v[1] & v[2]) ^ (v[2] & v[0]));
            for (int i = 7; i > 0; i--) v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_acc[i] = hash_acc[i] + v[i];
    endtask

    task automatic push_block_word(input logic [63:0] w);
        block_buf[fill_slot] = w;
        fill_slot = (fill_slot + 1) % 16;
        if (fill_slot == 0) compress_block();
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_acc[i] = init_hash(3'(i));
        fill_slot = 0;
        msg_bits  = '0;
    endtask

    task automatic absorb_item(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
        int unsigned n;
        logic [63:0] kept;
        digest_entry_t e;
        if (!fin) begin
            push_block_word(w);
            msg_bits = msg_bits + 64;
            return;
        end
        n = (cnt > 8) ? 8 : cnt;
        if (n == 8) begin
            push_block_word(w);
            push_block_word(PAD_WORD);
        end else begin
            kept = (n == 0) ? 64'd0 : (w & ({64{1'b1}} << (64 - 8 * n)));
            push_block_word(kept | (64'h80 << (56 - 8 * n)));
        end
        msg_bits = msg_bits + 8 * n;
        if (fill_slot == 15) push_block_word('0);
        while (fill_slot < 14) push_block_word('0);
        push_block_word('0);
        push_block_word(msg_bits);
        for (int k = 0; k < 8; k++) begin
            e.digest = hash_acc[k];
            e.index  = 3'(k);
            e.tail   = (k == 7);
            digest_queue.push_back(e);
        end
        restart_hash();
    endtask

    always @(posedge clk) begin
        digest_entry_t e;
        if (!rst_n) begin
            error_count = 0;
            digest_queue.delete();
            restart_hash();
        end else begin
            if (in_valid && in_ready) absorb_item(message_word, byte_count, last_word);
            if (out_valid && out_ready) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: unexpected digest word %h", $time, digest_word);
                    error_count++;
                end else begin
                    e = digest_queue.pop_front();
                    if (digest_word !== e.digest || word_number !== e.index
                        || last_of_digest !== e.tail) begin
                        $display("%0t: expected %h/%0d/%0b got %h/%0d/%0b", $time,
                                 e.digest, e.index, e.tail,
                                 digest_word, word_number, last_of_digest);
                        error_count++;
                    end
                end
            end
        end
        pending_count = digest_queue.size();
    end
endmodule

FILE: tb/sv/sha512_hash_core_tb.sv
`timescale 1ns / 1ps

module sha512_hash_core_tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_word;
    logic [2:0]  word_number;
    logic        last_of_digest;
    int          error_count;
    int          pending_count;

    // When set, the receiver and the sender stop idling so the tail of the run is back to back.
    bit          calm_tail;
    // Long receiver hold-off request, served by the output process.
    bit          hold_output;
    int          sent_items;

    sha512_hash_core i_dut (.*);

    sha512_digest_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stall bursts, plus one long stretch on request.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (600) @(negedge clk);
                hold_output = 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one item and holds it until the handshake completes. Valid is left
    // high on return so back-to-back items never drop it in between.
    task automatic send_item(input logic [63:0] w, input logic [3:0] cnt, input logic fin);
        message_word <= w;
        byte_count   <= cnt;
        last_word    <= fin;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    // Random gap on the sender side, only between items.
    task automatic maybe_gap();
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // One message of a given number of full words closed by a last word.
    task automatic send_message(input int full_words, input logic [3:0] cnt);
        for (int i = 0; i < full_words; i++)
        begin
            send_item({$urandom, $urandom}, 4'($urandom), 1'b0);
            maybe_gap();
        end
        send_item({$urandom, $urandom}, cnt, 1'b1);
        maybe_gap();
    endtask

    initial
    begin
        int n;
        in_valid     = 1'b0;
        message_word = '0;
        byte_count   = '0;
        last_word    = 1'b0;
        rst_n        = 1'b0;
        calm_tail    = 1'b0;
        hold_output  = 1'b0;
        sent_items   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: the empty message, all ones, all zeros, every byte count,
        // saturated counts above eight, and lengths around the padding boundary.
        send_item(64'h0, 4'd0, 1'b1);
        send_item({64{1'b1}}, 4'd8, 1'b1);
        send_item({64{1'b1}}, 4'd15, 1'b1);
        send_item(64'h0, 4'd8, 1'b1);
        for (int c = 1; c < 8; c++) send_item({$urandom, $urandom}, 4'(c), 1'b1);
        send_item({64{1'b1}}, 4'd9, 1'b1);
        wait_drained();
        send_message(13, 4'd8);
        send_message(14, 4'd0);
        wait_drained();

        // Let outputs back up for a long stretch while inputs keep coming.
        hold_output = 1'b1;
        send_message(20, 4'd3);
        send_message(2, 4'd8);
        wait_drained();

        // Random messages, mostly short, a few spanning block boundaries.
        while (sent_items < 100)
        begin
            if (sent_items > 85) calm_tail = 1'b1;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 33) : $urandom_range(0, 6);
            send_message(n, 4'($urandom_range(0, 15)));
        end
        wait_drained();

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: files.f
+incdir+sv
sv/sha512_pkg.sv
sv/sha512_front.sv
sv/sha512_back.sv
sv/sha512_hash_core.sv
tb/sv/sha512_digest_checker.sv
tb/sv/sha512_hash_core_tb.sv
